// ----- rtl/hvis_pkg.sv -----
// ----------------------------------------------------------------------------
// hvis_pkg
// Shared widths, register indexes and the result-drive bundle of the
// high-voltage interlock supervisor.
// ----------------------------------------------------------------------------
package hvis_pkg;

  // Debounce history depth and timestamp width
  localparam int HISTORY_WIDTH = 31;
  localparam int TIME_WIDTH    = 32;

  // Field widths
  localparam int SW_W     = 4;
  localparam int FAULT_W  = 8;
  localparam int NOW_W    = 32;
  localparam int OFF_W    = 16;
  localparam int DLEN_W   = 5;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 16;

  // Reset values of the configuration registers
  localparam logic [OFF_W-1:0]  HV_OFF_RESET = 16'd100;
  localparam logic [DLEN_W-1:0] DLEN_RESET   = 5'd6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HV_OFF_TIME = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 1'd1;

  // Switch bit positions
  localparam int SW_HV   = 0;
  localparam int SW_BEAM = 1;
  localparam int SW_CCS  = 2;
  localparam int SW_80KV = 3;

  // Enable drives produced by the mode machine
  typedef struct packed {
    logic ccs;
    logic beam;
    logic hv;
    logic nominal;
  } drive_t;

endpackage

// ----- rtl/hvis_debounce.sv -----
// ----------------------------------------------------------------------------
// hvis_debounce
// Shift-history debouncer for one input line: the level moves only after
// debounce_length equal samples in a row (clamped to 31; a length of zero holds it low).
// ----------------------------------------------------------------------------
module hvis_debounce (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              step,
  input  logic                              sample,
  input  logic [hvis_pkg::DLEN_W-1:0]       dlen,
  output logic                              level_next
);

  logic [hvis_pkg::HISTORY_WIDTH-1:0] history;
  logic [hvis_pkg::HISTORY_WIDTH-1:0] history_next;
  logic [hvis_pkg::HISTORY_WIDTH-1:0] win;
  logic [hvis_pkg::HISTORY_WIDTH-1:0] seen;
  logic [hvis_pkg::DLEN_W-1:0]        len;
  logic                               level;

  // Clamp the window to the history depth and build its mask
  always_comb begin
    if (32'(dlen) > 32'(hvis_pkg::HISTORY_WIDTH)) begin
      len = hvis_pkg::DLEN_W'(hvis_pkg::HISTORY_WIDTH);
    end else begin
      len = dlen;
    end
    win = ~({hvis_pkg::HISTORY_WIDTH{1'b1}} << len);
  end

  // Shift in the new sample and decide the level
  always_comb begin
    history_next = hvis_pkg::HISTORY_WIDTH'({history, sample});
    seen         = history_next & win;
    if (seen == '0) begin
      level_next = 1'b0;
    end else if (seen == win) begin
      level_next = 1'b1;
    end else begin
      level_next = level;
    end
  end

  // Advance on every accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      history <= '0;
      level   <= 1'b0;
    end else if (step) begin
      history <= history_next;
      level   <= level_next;
    end
  end

endmodule

// ----- rtl/hvis_mode.sv -----
// ----------------------------------------------------------------------------
// hvis_mode
// Three-mode interlock machine (interlock, nominal, hv-off timer) that gates
// the ccs, beam and high-voltage enables.
// ----------------------------------------------------------------------------
module hvis_mode (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                step,
  input  logic [hvis_pkg::SW_W-1:0]           deb,
  input  logic                                btn_rise,
  input  logic [hvis_pkg::FAULT_W-1:0]        faults,
  input  logic [hvis_pkg::TIME_WIDTH-1:0]     now,
  input  logic [hvis_pkg::OFF_W-1:0]          hv_off_time,
  output hvis_pkg::drive_t                    drive
);

  typedef enum logic [1:0] {
    MODE_INTERLOCK = 2'd0,
    MODE_NOMINAL   = 2'd1,
    MODE_TIMER     = 2'd2
  } mode_t;

  mode_t                           mode;
  mode_t                           mode_next;
  logic [hvis_pkg::TIME_WIDTH-1:0] timer_start;
  logic [hvis_pkg::TIME_WIDTH-1:0] elapsed;
  logic                            load_timer;
  logic                            deb_hv;
  logic                            deb_80kv;

  assign deb_hv   = deb[hvis_pkg::SW_HV];
  assign deb_80kv = deb[hvis_pkg::SW_80KV];
  assign elapsed  = now - timer_start;

  // Next mode and enable drives for this sample
  always_comb begin
    mode_next    = mode;
    load_timer   = 1'b0;
    drive        = '0;
    unique case (mode)
      MODE_NOMINAL: begin
        if (faults[1:0] != 2'b00) begin
          mode_next  = MODE_TIMER;
          load_timer = 1'b1;
        end else if (faults != '0 || !deb_80kv || !deb_hv) begin
          mode_next = MODE_INTERLOCK;
          drive.hv  = deb_hv;
        end else begin
          drive.hv   = deb_hv;
          drive.ccs  = deb[hvis_pkg::SW_CCS];
          drive.beam = deb[hvis_pkg::SW_BEAM];
        end
      end
      MODE_TIMER: begin
        if (32'(elapsed) >= 32'(hv_off_time)) begin
          mode_next = MODE_INTERLOCK;
        end
      end
      default: begin
        if (faults[0]) begin
          mode_next  = MODE_TIMER;
          load_timer = 1'b1;
        end else begin
          mode_next = MODE_INTERLOCK;
          drive.hv  = deb_hv;
          if (btn_rise && faults == '0 && deb_80kv && deb_hv) begin
            mode_next = MODE_NOMINAL;
          end
        end
      end
    endcase
    drive.nominal = (mode_next == MODE_NOMINAL);
  end

  // Hold mode and trip time
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_INTERLOCK;
      timer_start <= '0;
    end else if (step) begin
      mode <= mode_next;
      if (load_timer) begin
        timer_start <= now;
      end
    end
  end

endmodule

// ----- rtl/hv_interlock_supervisor_unit.sv -----
// ----------------------------------------------------------------------------
// hv_interlock_supervisor_unit
// High-voltage interlock supervisor: debounces switches and the reset button,
// runs the interlock mode machine and latches faults until an ack toggle.
//
//   channel   dir  width  contents
//   s_axis    in   48     raw_switches, comparator_faults, ack, button, now_ms
//   m_axis    out  16     enables, nominal flag, latched switches and faults
//   cfg       in   16     hv_off_time_ms (index 0), debounce_length (index 1)
//
// One sample is taken per cycle; its result appears in the output register
// on the next cycle. All state updates in the same cycle the sample is taken.
// The input stalls only while the output register is full and not taken.
// rst is synchronous and restores the reset values of all state and config but the output data word.
// ----------------------------------------------------------------------------
module hv_interlock_supervisor_unit (
  input  logic                                clk,
  input  logic                                rst,
  // Fields from bit 0: raw_switches[3:0], comparator_faults[11:4],
  // ack_level[12], reset_pressed[13], now_ms[45:14], zero pad[47:46]
  input  logic [hvis_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // Fields from bit 0: ccs_enable[0], beam_enable[1], hv_enable[2],
  // nominal_op[3], latched_switches[7:4], latched_faults[15:8]
  output logic [hvis_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                cfg_wen,
  input  logic [hvis_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hvis_pkg::CFG_W-1:0]          cfg_data
);

  logic                             step;
  logic [hvis_pkg::SW_W-1:0]        sw;
  logic [hvis_pkg::FAULT_W-1:0]     faults;
  logic                             ack;
  logic                             btn;
  logic [hvis_pkg::TIME_WIDTH-1:0]  now;

  logic [hvis_pkg::OFF_W-1:0]       hv_off_time;
  logic [hvis_pkg::DLEN_W-1:0]      dlen;

  logic [hvis_pkg::SW_W-1:0]        deb;
  logic                             btn_level;
  logic                             btn_prev;
  logic                             btn_rise;
  logic                             prev_ack;
  logic [hvis_pkg::FAULT_W-1:0]     fault_latch;
  logic [hvis_pkg::FAULT_W-1:0]     fault_latch_next;
  logic [hvis_pkg::SW_W-1:0]        switch_latch;
  logic [hvis_pkg::SW_W-1:0]        switch_latch_next;
  hvis_pkg::drive_t                 drive;

  // Unpack the input word
  assign sw     = s_axis_tdata[3:0];
  assign faults = s_axis_tdata[11:4];
  assign ack    = s_axis_tdata[12];
  assign btn    = s_axis_tdata[13];
  assign now    = s_axis_tdata[14 +: hvis_pkg::TIME_WIDTH];

  // Accept while the output register is free or being drained
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign step          = s_axis_tvalid && s_axis_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hv_off_time <= hvis_pkg::HV_OFF_RESET;
      dlen        <= hvis_pkg::DLEN_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        hvis_pkg::REG_HV_OFF_TIME: hv_off_time <= cfg_data;
        hvis_pkg::REG_DEBOUNCE:    dlen <= cfg_data[hvis_pkg::DLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Debounce the four switches
  for (genvar i = 0; i < hvis_pkg::SW_W; i++) begin : g_sw_deb
    hvis_debounce u_sw_deb (
      .clk        (clk),
      .rst        (rst),
      .step       (step),
      .sample     (sw[i]),
      .dlen       (dlen),
      .level_next (deb[i])
    );
  end

  // Debounce the reset button and find its rising edge
  hvis_debounce u_btn_deb (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .sample     (btn),
    .dlen       (dlen),
    .level_next (btn_level)
  );

  assign btn_rise = btn_level && !btn_prev;

  hvis_mode u_mode (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .deb         (deb),
    .btn_rise    (btn_rise),
    .faults      (faults),
    .now         (now),
    .hv_off_time (hv_off_time),
    .drive       (drive)
  );

  // Clear latches on an ack toggle, then gather this sample
  always_comb begin
    if (ack != prev_ack) begin
      fault_latch_next  = faults;
      switch_latch_next = sw;
    end else begin
      fault_latch_next  = fault_latch | faults;
      switch_latch_next = switch_latch | sw;
    end
  end

  // Hold latches and edge trackers
  always_ff @(posedge clk) begin
    if (rst) begin
      btn_prev     <= 1'b0;
      prev_ack     <= 1'b0;
      fault_latch  <= '0;
      switch_latch <= '0;
    end else if (step) begin
      btn_prev     <= btn_level;
      prev_ack     <= ack;
      fault_latch  <= fault_latch_next;
      switch_latch <= switch_latch_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (step) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_axis_tdata <= {fault_latch_next, switch_latch_next, drive.nominal,
                       drive.hv, drive.beam, drive.ccs};
    end
  end

endmodule

// ----- test/hvis_supervisor_checker.sv -----
// ----------------------------------------------------------------------------
// hvis_supervisor_checker
// Watches the sample, result and register-write ports of the interlock
// supervisor. It keeps its own copy of the debouncers, mode machine, timer and
// latches, computes the expected status word for every accepted sample, and
// compares each accepted result word, field by field, with the oldest one.
// ----------------------------------------------------------------------------
module hvis_supervisor_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [hvis_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [hvis_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic                             cfg_wen,
  input  logic [hvis_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hvis_pkg::CFG_W-1:0]       cfg_data,
  output int                               mismatches,
  output int                               pending,
  output int                               results_checked,
  output int                               nominal_results
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    MODE_INTERLOCK = 2'd0,
    MODE_NOMINAL   = 2'd1,
    MODE_TIMER     = 2'd2
  } sup_mode_e;

  // Result word, declared from the top bit down so it maps onto m_axis_tdata
  typedef struct packed {
    logic [hvis_pkg::FAULT_W-1:0] faults;
    logic [hvis_pkg::SW_W-1:0]    switches;
    logic                         nominal;
    logic                         hv;
    logic                         beam;
    logic                         ccs;
  } status_t;

  // Shadow registers and state
  logic [hvis_pkg::OFF_W-1:0]         off_ms;
  logic [hvis_pkg::DLEN_W-1:0]        dlen;
  sup_mode_e                          mode;
  logic [hvis_pkg::TIME_WIDTH-1:0]    trip_ms;
  logic [hvis_pkg::HISTORY_WIDTH-1:0] hist [5];   // entries 0..3 switches, 4 button
  logic                               lvl  [5];
  logic                               btn_prev;
  logic                               ack_prev;
  logic [hvis_pkg::FAULT_W-1:0]       fault_seen;
  logic [hvis_pkg::SW_W-1:0]          switch_seen;
  status_t                            expected_status [$];

  // Take one sample through debounce, mode machine and latches
  function automatic status_t advance_supervisor(input logic [hvis_pkg::IN_DATA_W-1:0] w);
    logic [hvis_pkg::SW_W-1:0]          sw;
    logic [hvis_pkg::FAULT_W-1:0]       flt;
    logic                               ack;
    logic [hvis_pkg::TIME_WIDTH-1:0]    now;
    logic [4:0]                         bits;
    logic [4:0]                         len;
    logic [hvis_pkg::HISTORY_WIDTH-1:0] win;
    logic                               rise;
    status_t                            r;
    sw   = w[3:0];
    flt  = w[11:4];
    ack  = w[12];
    bits = {w[13], sw};
    now  = w[14 +: hvis_pkg::TIME_WIDTH];
    len  = (dlen > hvis_pkg::HISTORY_WIDTH) ? 5'(hvis_pkg::HISTORY_WIDTH) : dlen;
    win  = (hvis_pkg::HISTORY_WIDTH'(1) << len) - hvis_pkg::HISTORY_WIDTH'(1);

    // Shift histories; a level moves only when the whole window agrees
    for (int i = 0; i < 5; i++) begin
      hist[i] = {hist[i][hvis_pkg::HISTORY_WIDTH-2:0], bits[i]};
      if ((hist[i] & win) == '0) lvl[i] = 1'b0;
      else if ((hist[i] & win) == win) lvl[i] = 1'b1;
    end
    rise     = lvl[4] & ~btn_prev;
    btn_prev = lvl[4];

    r = '0;
    case (mode)
      MODE_NOMINAL: begin
        if (flt[1:0] != 2'b00) begin
          mode    = MODE_TIMER;
          trip_ms = now;
        end else if (flt != '0 || !lvl[hvis_pkg::SW_80KV] || !lvl[hvis_pkg::SW_HV]) begin
          mode = MODE_INTERLOCK;
          r.hv = lvl[hvis_pkg::SW_HV];
        end else begin
          r.hv   = lvl[hvis_pkg::SW_HV];
          r.ccs  = lvl[hvis_pkg::SW_CCS];
          r.beam = lvl[hvis_pkg::SW_BEAM];
        end
      end
      MODE_TIMER: begin
        if (hvis_pkg::TIME_WIDTH'(now - trip_ms) >= hvis_pkg::TIME_WIDTH'(off_ms))
          mode = MODE_INTERLOCK;
      end
      default: begin
        if (flt[0]) begin
          mode    = MODE_TIMER;
          trip_ms = now;
        end else begin
          mode = MODE_INTERLOCK;
          r.hv = lvl[hvis_pkg::SW_HV];
          if (rise && flt == '0 && lvl[hvis_pkg::SW_80KV] && lvl[hvis_pkg::SW_HV])
            mode = MODE_NOMINAL;
        end
      end
    endcase

    // Any change of the ack level clears the latches before this sample adds
    if (ack != ack_prev) begin
      fault_seen  = '0;
      switch_seen = '0;
    end
    ack_prev    = ack;
    fault_seen  = fault_seen | flt;
    switch_seen = switch_seen | sw;

    r.nominal  = (mode == MODE_NOMINAL);
    r.switches = switch_seen;
    r.faults   = fault_seen;
    return r;
  endfunction

  // Track writes, check results, then queue the prediction for a new sample
  always @(posedge clk) begin
    status_t got_w;
    status_t want_w;
    if (rst) begin
      off_ms      = hvis_pkg::HV_OFF_RESET;
      dlen        = hvis_pkg::DLEN_RESET;
      mode        = MODE_INTERLOCK;
      trip_ms     = '0;
      btn_prev    = 1'b0;
      ack_prev    = 1'b0;
      fault_seen  = '0;
      switch_seen = '0;
      for (int i = 0; i < 5; i++) begin
        hist[i] = '0;
        lvl[i]  = 1'b0;
      end
      expected_status.delete();
    end else begin
      if (cfg_wen) begin
        if (cfg_index == hvis_pkg::REG_HV_OFF_TIME)
          off_ms = cfg_data[hvis_pkg::OFF_W-1:0];
        else if (cfg_index == hvis_pkg::REG_DEBOUNCE)
          dlen = cfg_data[hvis_pkg::DLEN_W-1:0];
      end

      if (m_axis_tvalid && m_axis_tready) begin
        got_w = status_t'(m_axis_tdata);
        if (expected_status.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result word 0x%04h with no sample outstanding", $time, got_w);
          mismatches++;
        end else begin
          want_w = expected_status.pop_front();
          results_checked++;
          if (want_w.nominal) nominal_results++;
          if (got_w.ccs !== want_w.ccs || got_w.beam !== want_w.beam ||
              got_w.hv !== want_w.hv || got_w.nominal !== want_w.nominal ||
              got_w.switches !== want_w.switches || got_w.faults !== want_w.faults) begin
            if (mismatches < 10)
              $display({"%0t: mismatch ccs/beam/hv/nom/sw/flt expected %b%b%b%b %h %h",
                        " got %b%b%b%b %h %h"}, $time,
                       want_w.ccs, want_w.beam, want_w.hv, want_w.nominal,
                       want_w.switches, want_w.faults,
                       got_w.ccs, got_w.beam, got_w.hv, got_w.nominal,
                       got_w.switches, got_w.faults);
            mismatches++;
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready)
        expected_status.push_back(advance_supervisor(s_axis_tdata));
    end
    pending <= expected_status.size();
  end

  initial begin
    mismatches      = 0;
    pending         = 0;
    results_checked = 0;
    nominal_results = 0;
  end

endmodule

// ----- test/hv_interlock_supervisor_unit_tb.sv -----
// ----------------------------------------------------------------------------
// hv_interlock_supervisor_unit_tb
// Drives samples into the interlock supervisor: a directed opening over the
// field extremes, timer wrap, every mode change and ack clearing, then random
// arm/run/trip sequences mixed with noise across several register settings,
// with random idling on both sides. The checker does all comparing.
// ----------------------------------------------------------------------------
module hv_interlock_supervisor_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 5000;

  logic                            clk;
  logic                            rst;
  logic [hvis_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [hvis_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic                            cfg_wen;
  logic [hvis_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [hvis_pkg::CFG_W-1:0]      cfg_data;

  int mismatches, pending, results_checked, nominal_results;

  // Stimulus state
  int          src_idle_pct;
  int          sink_idle_pct;
  int          samples_sent;
  int          reg_writes;
  int          quiet_cycles;
  logic        ack_lvl;
  logic [31:0] now_ctr;
  logic [15:0] cur_off;
  logic [4:0]  cur_dlen;

  hv_interlock_supervisor_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  hvis_supervisor_checker u_check (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .cfg_wen         (cfg_wen),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .pending         (pending),
    .results_checked (results_checked),
    .nominal_results (nominal_results)
  );

  always #5 clk = ~clk;

  // Result side: stall at random
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Offer one sample word and hold it until accepted
  task automatic send_sample(input logic [3:0] sw, input logic [7:0] flt, input logic ack,
                             input logic btn, input logic [31:0] now);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, now, btn, ack, flt, sw};
    do @(posedge clk); while (!s_axis_tready);
    samples_sent++;
  endtask

  // Random sample: advance time, toggle ack now and then
  task automatic step(input logic [3:0] sw, input logic [7:0] flt, input logic btn);
    if ($urandom_range(0, 99) < 8) ack_lvl = ~ack_lvl;
    now_ctr = now_ctr + $urandom_range(0, cur_off / 4 + 2);
    send_sample(sw, flt, ack_lvl, btn, now_ctr);
  endtask

  // Drain all results, pause, then write one register
  task automatic write_reg(input logic [hvis_pkg::CFG_IDX_W-1:0] idx,
                           input logic [hvis_pkg::CFG_W-1:0] val);
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (2) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    reg_writes++;
    if (idx == hvis_pkg::REG_HV_OFF_TIME) cur_off = val[hvis_pkg::OFF_W-1:0];
    else cur_dlen = val[hvis_pkg::DLEN_W-1:0];
  endtask

  // Arm, press the button, run, then end the run in one of several ways
  task automatic run_episode();
    logic [3:0] arm;
    logic [7:0] flt;
    int         hold;
    arm  = 4'b1001 | (4'($urandom) & 4'b0110);
    hold = cur_dlen + $urandom_range(0, 2);
    repeat (hold) step(arm, 8'h00, 1'b0);
    repeat (hold) step(arm, 8'h00, 1'b1);
    repeat ($urandom_range(1, 12))
      step(($urandom_range(0, 99) < 20) ? arm ^ (4'($urandom) & 4'b0110) : arm, 8'h00,
           1'($urandom));
    case ($urandom_range(0, 4))
      0: begin
        // current trip, then sit out the timer
        flt = 8'($urandom) | 8'h01;
        step(arm, flt, 1'b0);
        repeat ($urandom_range(4, 14)) step(arm, 8'($urandom), 1'b0);
      end
      1: begin
        // voltage trip only
        flt = (8'($urandom) & 8'hFE) | 8'h02;
        step(arm, flt, 1'b0);
        repeat ($urandom_range(4, 14)) step(arm, 8'($urandom) & 8'hFE, 1'b0);
      end
      2: step(arm, 8'($urandom_range(1, 63)) << 2, 1'b0);
      3: repeat (hold) step(arm & ~(($urandom_range(0, 1) != 0) ? 4'b0001 : 4'b1000),
                            8'h00, 1'b0);
      default: ;
    endcase
  endtask

  task automatic run_phase(input logic [15:0] off, input logic [4:0] dl, input int idle_pct,
                           input int count);
    int first;
    write_reg(hvis_pkg::REG_HV_OFF_TIME, off);
    write_reg(hvis_pkg::REG_DEBOUNCE, {11'($urandom), dl});
    src_idle_pct  = idle_pct;
    sink_idle_pct = idle_pct;
    first = samples_sent;
    while (samples_sent - first < count) begin
      if ($urandom_range(0, 99) < 80) begin
        run_episode();
      end else begin
        if ($urandom_range(0, 9) == 0) now_ctr = $urandom;
        step(4'($urandom), ($urandom_range(0, 1) != 0) ? 8'($urandom) : 8'h00, 1'($urandom));
      end
    end
  endtask

  initial begin
    clk           = 1'b0;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_wen       = 1'b0;
    cfg_index     = hvis_pkg::REG_HV_OFF_TIME;
    cfg_data      = '0;
    m_axis_tready = 1'b0;
    quiet_cycles  = 0;
    samples_sent  = 0;
    reg_writes    = 0;
    ack_lvl       = 1'b0;
    now_ctr       = 32'd0;
    cur_off       = hvis_pkg::HV_OFF_RESET;
    cur_dlen      = hvis_pkg::DLEN_RESET;
    src_idle_pct  = 18;
    sink_idle_pct = 18;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: all-zero and all-one words, timer across the wrap
    send_sample(4'h0, 8'h00, 1'b0, 1'b0, 32'h0000_0000);
    send_sample(4'hF, 8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
    send_sample(4'h0, 8'h00, 1'b1, 1'b0, 32'h0000_0062);
    send_sample(4'h0, 8'h00, 1'b1, 1'b0, 32'h0000_0063);
    send_sample(4'h0, 8'h02, 1'b0, 1'b0, 32'h0000_0070);

    // One-sample debounce, zero off time: walk every mode change
    write_reg(hvis_pkg::REG_HV_OFF_TIME, 16'd0);
    write_reg(hvis_pkg::REG_DEBOUNCE, 16'd1);
    send_sample(4'h9, 8'h00, 1'b0, 1'b0, 32'd1000);
    send_sample(4'h9, 8'h00, 1'b0, 1'b1, 32'd1001);
    send_sample(4'hF, 8'h00, 1'b0, 1'b0, 32'd1002);
    send_sample(4'hF, 8'h04, 1'b0, 1'b1, 32'd1003);
    send_sample(4'h9, 8'h00, 1'b0, 1'b1, 32'd1004);
    send_sample(4'h9, 8'h00, 1'b0, 1'b0, 32'd1005);
    send_sample(4'h9, 8'h00, 1'b0, 1'b1, 32'd1006);
    send_sample(4'hF, 8'h02, 1'b1, 1'b0, 32'd1007);
    send_sample(4'hF, 8'h00, 1'b1, 1'b0, 32'd1007);
    send_sample(4'h9, 8'h00, 1'b0, 1'b0, 32'd1008);
    send_sample(4'h9, 8'h00, 1'b0, 1'b1, 32'd1009);
    send_sample(4'h8, 8'h00, 1'b0, 1'b1, 32'd1010);
    send_sample(4'hF, 8'h01, 1'b1, 1'b0, 32'd1011);
    send_sample(4'h1, 8'h80, 1'b1, 1'b0, 32'd1011);
    ack_lvl = 1'b1;
    now_ctr = 32'd2000;

    // Random part over several settings, extremes included
    run_phase(hvis_pkg::HV_OFF_RESET, hvis_pkg::DLEN_RESET, 18, 110);
    run_phase(16'd0, 5'd1, 18, 100);
    run_phase(16'hFFFF, 5'd31, 0, 120);
    run_phase(16'($urandom_range(1, 300)), 5'd0, 18, 60);
    run_phase(16'($urandom), 5'($urandom_range(1, 31)), 18, 110);
    run_phase(16'd1, 5'd2, 18, 100);

    // Drain and settle
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);

    $display("Sent %0d samples over %0d register writes; %0d results checked, %0d in nominal.",
             samples_sent, reg_writes, results_checked, nominal_results);
    if (mismatches == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
